// ===== rtl/length_checksum_packet_deframer_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Packet deframer assertion macros
// Shared concurrent assertion forms, clocked on aclk, held off during reset.
// ----------------------------------------------------------------------------
`ifndef LENGTH_CHECKSUM_PACKET_DEFRAMER_UNIT_DEFINES_SVH
`define LENGTH_CHECKSUM_PACKET_DEFRAMER_UNIT_DEFINES_SVH

// same-cycle implication
`define LCPD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("lcpd: same-cycle check failed");

// next-cycle implication
`define LCPD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("lcpd: next-cycle check failed");

`endif

// ===== rtl/lcpd_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Packet deframer package
// Payload structs, operation and error codes, and shared constants.
// ----------------------------------------------------------------------------
package lcpd_pkg;

    localparam int unsigned BUFFER_BYTES = 256;
    localparam logic [7:0] IDLE_TIMEOUT_RESET = 8'd50;
    localparam logic [15:0] MIN_LENGTH = 16'd4;

    typedef enum logic [1:0] {
        OP_BYTE       = 2'd0,
        OP_LINE_ERROR = 2'd1,
        OP_TICK       = 2'd2,
        OP_CONSUME    = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ERR_NONE         = 2'd0,
        ERR_CHECKSUM     = 2'd1,
        ERR_SHORT_LENGTH = 2'd2
    } err_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] rx_byte;
    } in_item_t;

    typedef struct packed {
        logic        store_valid;
        logic [7:0]  store_index;
        logic [7:0]  store_data;
        logic        packet_ready;
        logic [15:0] frame_length;
        logic [15:0] packet_command;
        logic [1:0]  error_code;
        logic        resynced;
    } out_item_t;

    // classified beat handed from the front end to the back end
    typedef struct packed {
        logic       is_byte;
        logic       is_line_error;
        logic       is_tick;
        logic       is_consume;
        logic [7:0] data;
    } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/lcpd_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Packet deframer command queue
// Two-entry queue between front and back end; push and pop may occur in the same cycle.
// ----------------------------------------------------------------------------
module lcpd_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire lcpd_pkg::cmd_t in_cmd,
    output logic               out_valid,
    input  wire logic          out_ready,
    output lcpd_pkg::cmd_t     out_cmd
);

    lcpd_pkg::cmd_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           rd_ptr_reg;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           push;
    logic           pop;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 2'd1;
        end else if (pop && !push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/lcpd_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Packet deframer front end
// Accepts input beats, decodes the operation and queues the result.
// ----------------------------------------------------------------------------
module lcpd_front (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire lcpd_pkg::in_item_t s_data,
    output logic                    q_valid,
    input  wire logic               q_ready,
    output lcpd_pkg::cmd_t          q_cmd
);

    lcpd_pkg::cmd_t dec_cmd;

    always_comb begin
        dec_cmd      = '0;
        dec_cmd.data = s_data.rx_byte;
        unique case (lcpd_pkg::op_t'(s_data.operation))
            lcpd_pkg::OP_BYTE:       dec_cmd.is_byte       = 1'b1;
            lcpd_pkg::OP_LINE_ERROR: dec_cmd.is_line_error = 1'b1;
            lcpd_pkg::OP_TICK:       dec_cmd.is_tick       = 1'b1;
            lcpd_pkg::OP_CONSUME:    dec_cmd.is_consume    = 1'b1;
            default:                 dec_cmd.is_consume    = 1'b1;
        endcase
    end

    lcpd_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_cmd    (dec_cmd),
        .out_valid (q_valid),
        .out_ready (q_ready),
        .out_cmd   (q_cmd)
    );

endmodule

`default_nettype wire

// ===== rtl/lcpd_back.sv =====
`default_nettype none
`include "length_checksum_packet_deframer_unit_defines.svh"
// ----------------------------------------------------------------------------
// Packet deframer back end
// Framing state, checksum, idle timer and the registered result beat.
// ----------------------------------------------------------------------------
module lcpd_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_valid,
    input  wire logic [7:0]     cfg_data,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  wire lcpd_pkg::cmd_t q_cmd,
    output logic                m_valid,
    input  wire logic           m_ready,
    output lcpd_pkg::out_item_t m_data
);

    localparam logic [16:0] BUF_LIMIT = 17'(lcpd_pkg::BUFFER_BYTES);

    logic [16:0]         pos_reg,      pos_next;
    logic                known_reg,    known_next;
    logic [15:0]         exp_len_reg,  exp_len_next;
    logic [7:0]          len_hi_reg,   len_hi_next;
    logic [15:0]         cmd_word_reg, cmd_word_next;
    logic [15:0]         run_sum_reg,  run_sum_next;
    logic [15:0]         rcv_sum_reg,  rcv_sum_next;
    logic                pending_reg,  pending_next;
    logic [7:0]          idle_left_reg, idle_left_next;
    logic [7:0]          timeout_reg;
    logic                m_valid_reg;
    lcpd_pkg::out_item_t m_data_reg,   m_data_next;
    logic                pop;

    assign q_ready = !m_valid_reg || m_ready;
    assign pop     = q_valid && q_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    always_comb begin
        logic [16:0] pos_base;
        logic [16:0] limit;
        logic [15:0] sum_base;
        logic [15:0] len_word;
        logic [15:0] rcv_word;
        lcpd_pkg::err_t err;

        pos_next       = pos_reg;
        known_next     = known_reg;
        exp_len_next   = exp_len_reg;
        len_hi_next    = len_hi_reg;
        cmd_word_next  = cmd_word_reg;
        run_sum_next   = run_sum_reg;
        rcv_sum_next   = rcv_sum_reg;
        pending_next   = pending_reg;
        idle_left_next = idle_left_reg;
        m_data_next    = '0;
        err            = lcpd_pkg::ERR_NONE;
        pos_base       = pos_reg;
        limit          = 17'h0ffff;
        sum_base       = run_sum_reg;
        len_word       = {len_hi_reg, q_cmd.data};
        rcv_word       = {rcv_sum_reg[15:8], q_cmd.data};

        if (q_cmd.is_byte) begin
            idle_left_next = timeout_reg;
            if (!pending_reg) begin
                // silence ran out: framing starts over with this beat
                if (idle_left_reg == 8'd0) begin
                    pos_base             = 17'd0;
                    known_next           = 1'b0;
                    m_data_next.resynced = 1'b1;
                end
                limit        = known_next ? {1'b0, exp_len_reg} : 17'h0ffff;
                sum_base     = (pos_base == 17'd0) ? 16'd0 : run_sum_reg;
                pos_next     = pos_base;
                run_sum_next = sum_base;

                if (pos_base < limit) begin
                    if (pos_base < BUF_LIMIT) begin
                        m_data_next.store_valid = 1'b1;
                        m_data_next.store_index = pos_base[7:0];
                        m_data_next.store_data  = q_cmd.data;
                    end
                    run_sum_next = sum_base + {8'd0, q_cmd.data};
                    pos_next     = pos_base + 17'd1;
                    if (pos_base == 17'd0) begin
                        cmd_word_next = {q_cmd.data, cmd_word_reg[7:0]};
                    end else if (pos_base == 17'd1) begin
                        cmd_word_next = {cmd_word_reg[15:8], q_cmd.data};
                    end else if (pos_base == 17'd2) begin
                        len_hi_next = q_cmd.data;
                    end else if (pos_base == 17'd3) begin
                        exp_len_next = len_word;
                        known_next   = 1'b1;
                        if (len_word < lcpd_pkg::MIN_LENGTH) begin
                            err        = lcpd_pkg::ERR_SHORT_LENGTH;
                            pos_next   = 17'd0;
                            known_next = 1'b0;
                        end
                    end
                end else if (pos_base == limit) begin
                    rcv_sum_next = {q_cmd.data, 8'd0};
                    pos_next     = pos_base + 17'd1;
                end else if (pos_base == limit + 17'd1) begin
                    rcv_sum_next = rcv_word;
                    pos_next     = pos_base + 17'd1;
                    if (rcv_word == sum_base) begin
                        pending_next = 1'b1;
                    end else begin
                        err        = lcpd_pkg::ERR_CHECKSUM;
                        pos_next   = 17'd0;
                        known_next = 1'b0;
                    end
                end else begin
                    pos_next   = 17'd0;
                    known_next = 1'b0;
                end
            end
        end else if (q_cmd.is_line_error) begin
            if (!pending_reg) begin
                pos_next             = 17'd0;
                known_next           = 1'b0;
                m_data_next.resynced = 1'b1;
            end
        end else if (q_cmd.is_tick) begin
            if (idle_left_reg != 8'd0) begin
                idle_left_next = idle_left_reg - 8'd1;
            end
        end else begin
            if (pending_reg) begin
                pending_next = 1'b0;
                pos_next     = 17'd0;
                known_next   = 1'b0;
            end
        end

        m_data_next.error_code     = err;
        m_data_next.packet_ready   = pending_next;
        m_data_next.frame_length   = exp_len_next;
        m_data_next.packet_command = cmd_word_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= 17'd0;
            known_reg     <= 1'b0;
            exp_len_reg   <= 16'd0;
            len_hi_reg    <= 8'd0;
            cmd_word_reg  <= 16'd0;
            run_sum_reg   <= 16'd0;
            rcv_sum_reg   <= 16'd0;
            pending_reg   <= 1'b0;
            idle_left_reg <= 8'd0;
            timeout_reg   <= lcpd_pkg::IDLE_TIMEOUT_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_valid) begin
                timeout_reg <= cfg_data;
            end
            if (pop) begin
                pos_reg       <= pos_next;
                known_reg     <= known_next;
                exp_len_reg   <= exp_len_next;
                len_hi_reg    <= len_hi_next;
                cmd_word_reg  <= cmd_word_next;
                run_sum_reg   <= run_sum_next;
                rcv_sum_reg   <= rcv_sum_next;
                pending_reg   <= pending_next;
                idle_left_reg <= idle_left_next;
                m_valid_reg   <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            m_data_reg <= m_data_next;
        end
    end

    // a held packet blocks storing and resync
    `LCPD_ASSERT_NEXT(a_pending_blocks, aclk, aresetn,
        pop && pending_reg && !q_cmd.is_consume,
        !m_data_reg.store_valid && !m_data_reg.resynced && m_data_reg.packet_ready)

    // any reported error leaves framing at its start
    `LCPD_ASSERT_NEXT(a_error_restarts, aclk, aresetn,
        pop && (m_data_next.error_code != 2'(lcpd_pkg::ERR_NONE)),
        pos_reg == 17'd0 && !known_reg)

    // ticks count the idle timer down by one
    `LCPD_ASSERT_NEXT(a_tick_counts_down, aclk, aresetn,
        pop && q_cmd.is_tick && idle_left_reg != 8'd0,
        idle_left_reg == $past(idle_left_reg) - 8'd1)

endmodule

`default_nettype wire

// ===== rtl/length_checksum_packet_deframer_unit.sv =====
`default_nettype none
// Path: an accepted input beat is written into a queue slot, and its result
// beat is then written into the output register.
// Throughput: one beat per cycle while m_ready stays high; the two-entry
// queue and the output register let input and output stall independently.
// Reset: synchronous on aresetn low; framing, sums and idle timer clear to zero,
// the idle timeout register loads 50 ticks, queue and output empty.
// ----------------------------------------------------------------------------
// Length-prefixed packet deframer
// Splits length-prefixed packets, checks the 16-bit additive checksum and
// hands each stored byte on with its buffer index.
// ----------------------------------------------------------------------------
module length_checksum_packet_deframer_unit (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire lcpd_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output lcpd_pkg::out_item_t      m_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [7:0]          cfg_data
);

    logic           q_valid;
    logic           q_ready;
    lcpd_pkg::cmd_t q_cmd;

    assign cfg_ready = 1'b1;

    lcpd_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_cmd   (q_cmd)
    );

    lcpd_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_cmd     (q_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
